### design/ppu_pkg.sv
// shared constants, codes and types of the palette pixel line unpacker
package ppu_pkg;

    localparam int PIXELS_PER_LINE = 64;
    localparam int PALETTE_DEPTH   = 256;
    localparam int PAL_AW          = $clog2(PALETTE_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int COLOR_W = 24;
    localparam int LINE_W  = 16;
    localparam int PIX_W   = 8;

    // image formats
    typedef enum logic [1:0] {
        FMT_1BIT = 2'd0,
        FMT_4BIT = 2'd1,
        FMT_8BIT = 2'd2,
        FMT_TRUE = 2'd3
    } fmt_t;

    // configuration register indexes
    localparam logic CFG_IMAGE_FORMAT = 1'b0;
    localparam logic CFG_LINE_COUNT   = 1'b1;

    // input operations
    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_DATA_BYTE     = 1'b1;

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    // one command between front and back
    typedef struct packed {
        logic                 is_pixel;
        fmt_t                 fmt;
        logic [7:0]           pal_index;
        logic [COLOR_W-1:0]   value;
    } cmd_t;

endpackage

### design/ppu_ifs.sv
// channel interfaces: input items, output pixels, configuration writes

interface ppu_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [7:0]  data_byte;

    modport source (output valid, operation, palette_index, palette_color, data_byte,
                    input ready);
    modport sink   (input valid, operation, palette_index, palette_color, data_byte,
                    output ready);
endinterface

interface ppu_pixel_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] line_number;
    logic        end_of_line;
    logic        last;

    modport source (output valid, pixel_index, red, green, blue, line_number,
                    end_of_line, last, input ready);
    modport sink   (input valid, pixel_index, red, green, blue, line_number,
                    end_of_line, last, output ready);
endinterface

interface ppu_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/ppu_front.sv
// front end: config registers, request intake, truecolor byte assembly
module ppu_front
    import ppu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ppu_item_if.sink            item,
    ppu_cfg_if.sink             cfg,
    input  logic                q_full,
    output logic                push,
    output cmd_t                push_cmd,
    output logic [LINE_W-1:0]   line_count
);

    fmt_t              fmt_reg;
    logic [LINE_W-1:0] line_count_reg;
    logic [1:0]        phase_reg;
    logic [15:0]       held_rg_reg;

    logic accept;
    logic cfg_we;

    assign item.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign cfg_we     = cfg.valid && cfg.ready;
    assign line_count = line_count_reg;

    // partial truecolor bytes make no command
    assign push = accept && (item.operation == OP_PALETTE_WRITE ||
                             fmt_reg != FMT_TRUE || phase_reg == 2'd2);

    always_comb
    begin
        push_cmd.is_pixel = (item.operation == OP_DATA_BYTE);
        push_cmd.fmt      = fmt_reg;
        if (item.operation == OP_PALETTE_WRITE)
        begin
            push_cmd.pal_index = item.palette_index;
            push_cmd.value     = item.palette_color;
        end
        else
        begin
            push_cmd.pal_index = item.data_byte;
            push_cmd.value     = {held_rg_reg, item.data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= FMT_1BIT;
            line_count_reg <= 16'd1;
            phase_reg      <= 2'd0;
            held_rg_reg    <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg.index)
                    CFG_IMAGE_FORMAT:
                    begin
                        fmt_reg   <= fmt_t'(cfg.data[1:0]);
                        phase_reg <= 2'd0;
                    end
                    CFG_LINE_COUNT:
                        // zero behaves as one
                        line_count_reg <= (cfg.data == 16'd0) ? 16'd1 : cfg.data;
                    default: ;
                endcase
            end
            if (accept && item.operation == OP_DATA_BYTE)
            begin
                if (fmt_reg != FMT_TRUE)
                    phase_reg <= 2'd0;
                else
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            held_rg_reg <= {item.data_byte, 8'd0};
                            phase_reg   <= 2'd1;
                        end
                        2'd1:
                        begin
                            held_rg_reg <= {held_rg_reg[15:8], item.data_byte};
                            phase_reg   <= 2'd2;
                        end
                        default:
                            phase_reg <= 2'd0;
                    endcase
                end
            end
        end
    end

endmodule

### design/ppu_queue.sv
// short command queue between front and back
module ppu_queue
    import ppu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

### design/ppu_back.sv
// back end: palette memory, pixel sequencer, position counters, output stage
module ppu_back
    import ppu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  cmd_t               q_cmd,
    output logic               pop,
    input  logic [LINE_W-1:0]  line_count,
    ppu_pixel_if.source        pixel
);

    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    cmd_t        cur_reg;
    logic        cur_valid_reg;
    logic [2:0]  step_reg;

    logic [PIX_W-1:0]  pix_cnt_reg, pix_cnt_next;
    logic [LINE_W-1:0] line_reg, line_next;

    // read stage
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [LINE_W-1:0]  s1_line_reg;
    logic               s1_eol_reg;
    logic               s1_last_reg;
    logic               s1_true_reg;
    logic               s1_black_reg;
    logic [COLOR_W-1:0] s1_color_reg;

    // output stage
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic [LINE_W-1:0]  out_line_reg;
    logic               out_eol_reg;
    logic               out_last_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic [7:0]  byte_v;
    logic [7:0]  pal_idx;
    logic [2:0]  last_step;
    logic        adv, s1_free, issue, cur_done, pal_we, eol;
    logic [LINE_W:0] line_inc;

    assign byte_v = cur_reg.value[7:0];

    always_comb
    begin
        case (cur_reg.fmt)
            FMT_1BIT:
            begin
                pal_idx   = {7'd0, byte_v[step_reg]};
                last_step = 3'd7;
            end
            FMT_4BIT:
            begin
                pal_idx   = (step_reg == 3'd0) ? ((byte_v >> 4) & NIBBLE_MASK)
                                               : (byte_v & NIBBLE_MASK);
                last_step = 3'd1;
            end
            default:
            begin
                pal_idx   = byte_v;
                last_step = 3'd0;
            end
        endcase
    end

    assign adv      = !out_valid_reg || pixel.ready;
    assign s1_free  = !s1_valid_reg || adv;
    assign issue    = cur_valid_reg && cur_reg.is_pixel && s1_free;
    assign cur_done = cur_valid_reg &&
                      (!cur_reg.is_pixel || (issue && step_reg == last_step));
    assign pop      = q_not_empty && (!cur_valid_reg || cur_done);
    assign pal_we   = cur_valid_reg && !cur_reg.is_pixel &&
                      ({1'b0, cur_reg.pal_index} < 9'(PALETTE_DEPTH));

    // position of the next pixel
    assign eol      = (pix_cnt_reg >= PIX_W'(PIXELS_PER_LINE - 1));
    assign line_inc = {1'b0, line_reg} + (LINE_W+1)'(1);

    always_comb
    begin
        pix_cnt_next = pix_cnt_reg;
        line_next    = line_reg;
        if (issue)
        begin
            if (eol)
            begin
                pix_cnt_next = '0;
                line_next    = (line_inc >= {1'b0, line_count}) ? '0
                                                                : line_inc[LINE_W-1:0];
            end
            else
                pix_cnt_next = pix_cnt_reg + PIX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[cur_reg.pal_index[PAL_AW-1:0]] <= cur_reg.value;
        if (issue)
            rd_data_reg <= pal_mem[pal_idx[PAL_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_cmd;
        if (issue)
        begin
            s1_pix_reg   <= pix_cnt_reg;
            s1_line_reg  <= line_reg;
            s1_eol_reg   <= eol;
            s1_last_reg  <= (step_reg == last_step);
            s1_true_reg  <= (cur_reg.fmt == FMT_TRUE);
            s1_black_reg <= ({1'b0, pal_idx} >= 9'(PALETTE_DEPTH));
            s1_color_reg <= cur_reg.value;
        end
        if (adv && s1_valid_reg)
        begin
            out_pix_reg   <= s1_pix_reg;
            out_line_reg  <= s1_line_reg;
            out_eol_reg   <= s1_eol_reg;
            out_last_reg  <= s1_last_reg;
            out_color_reg <= s1_true_reg  ? s1_color_reg :
                             s1_black_reg ? '0 : rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            pix_cnt_reg   <= '0;
            line_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 3'd0;
            end
            else if (cur_done)
                cur_valid_reg <= 1'b0;
            else if (issue)
                step_reg <= step_reg + 3'd1;
            pix_cnt_reg <= pix_cnt_next;
            line_reg    <= line_next;
            if (s1_free)
                s1_valid_reg <= issue;
            if (adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_index = out_pix_reg;
    assign pixel.red         = out_color_reg[23:16];
    assign pixel.green       = out_color_reg[15:8];
    assign pixel.blue        = out_color_reg[7:0];
    assign pixel.line_number = out_line_reg;
    assign pixel.end_of_line = out_eol_reg;
    assign pixel.last        = out_last_reg;

endmodule

### design/palette_pixel_line_unpacker.sv
// top level of the palette pixel line unpacker
//
// channels (valid/ready, a request moves when both are high):
//   item  - palette writes (operation 0) and image data bytes (operation 1)
//   pixel - one RGB pixel per request with its line position, line number,
//           end_of_line and last (last pixel caused by one data byte)
//   cfg   - register writes: index 0 image_format, index 1 line_count;
//           always ready; the user must write only while the block is idle, not enforced
// the front takes one item request per cycle while the queue is not full,
// assembles truecolor triples and pushes commands into a four-entry queue;
// the back drains it, one palette write or, unless the pixel receiver stalls, one pixel per cycle
// a data byte's first pixel passes the queue, the current command register, the read
// stage and the output stage; throughput: one pixel per cycle unless the receiver stalls,
// set by the single palette read port; a one-bit byte gives 8 pixels, a four-bit byte 2
// reset: counters, byte phase and queue clear, image_format 0, line_count 1;
// the palette memory holds nothing defined until written
// a stalled pixel receiver holds the output register; the back then stops
// and the queue fills before item ready drops
module palette_pixel_line_unpacker
    import ppu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ppu_item_if.sink     item,
    ppu_pixel_if.source  pixel,
    ppu_cfg_if.sink      cfg
);

    logic              q_full;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    logic              q_not_empty;
    cmd_t              head_cmd;
    logic [LINE_W-1:0] line_count;

    // request intake and config registers
    ppu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .line_count (line_count)
    );

    // decouples intake from pixel output
    ppu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // palette lookup and pixel sequencing
    ppu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .pop         (pop),
        .line_count  (line_count),
        .pixel       (pixel)
    );

endmodule

### design/ppu_checker.sv
// port checker for the palette pixel line unpacker, with its bind
module ppu_checker
    import ppu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_pix,
    input logic [15:0] out_line,
    input logic        out_eol,
    input logic        out_last
);

    // a stalled pixel stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel dropped while stalled");

    // a stalled pixel keeps its position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pix) && $stable(out_line)
                                    && $stable(out_eol) && $stable(out_last))
        else $error("pixel changed while stalled");

    // end of line exactly on the last position of the line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_eol == (out_pix == 8'(PIXELS_PER_LINE - 1))))
        else $error("end_of_line does not match pixel position");

    // nothing offered under reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("pixel offered during reset");

endmodule

bind palette_pixel_line_unpacker ppu_checker u_ppu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .out_pix   (pixel.pixel_index),
    .out_line  (pixel.line_number),
    .out_eol   (pixel.end_of_line),
    .out_last  (pixel.last)
);

### tb/sv/testbench.sv
// self-checking testbench of the palette pixel line unpacker
module testbench;
    import ppu_pkg::*;

    // one item request: palette write or image data byte
    typedef struct packed {
        logic        op;
        logic [7:0]  pal_idx;
        logic [23:0] color;
        logic [7:0]  data;
    } req_t;

    // one pixel request as it leaves the block
    typedef struct packed {
        logic [7:0]  pos;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] line;
        logic        eol;
        logic        last;
    } pix_t;

    localparam int SETTLE_CYCLES = 16;     // queue depth plus pipeline, with margin
    localparam int DRAIN_LIMIT   = 20000;  // cycles a phase may take to empty

    logic clk;
    logic rst_n;

    ppu_item_if  item_ch ();
    ppu_pixel_if pix_ch ();
    ppu_cfg_if   cfg_ch ();

    palette_pixel_line_unpacker uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pixel (pix_ch),
        .cfg   (cfg_ch)
    );

    // clock: period of 2
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // shared state between stimulus, driver and monitor
    // ------------------------------------------------------------------
    req_t items_to_send [$];      // requests waiting for the driver
    pix_t pixels_due [$];         // predicted pixels, oldest first
    int   items_in_flight = 0;    // queued but not yet accepted by the block
    logic item_fire = 1'b0;       // item request accepted at the last rising edge
    int   fail_count = 0;

    // idling control
    logic idle_on = 1'b1;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   gap_left = 0;
    int   stall_left = 0;

    // palette entries that the stimulus has written so far
    logic [255:0] pal_written = '0;

    // ------------------------------------------------------------------
    // predictor state: own copy of registers, palette and counters
    // ------------------------------------------------------------------
    logic [23:0] palette_mem [0:255];
    fmt_t        fmt_cur = FMT_1BIT;
    logic [15:0] lines_cfg = 16'd1;
    logic [7:0]  pix_pos = '0;
    logic [15:0] line_now = '0;
    logic [1:0]  tc_phase = '0;
    logic [15:0] tc_held = '0;

    // entries past the palette depth read as black
    function automatic logic [23:0] pal_lookup(input logic [7:0] idx);
        if (idx < PALETTE_DEPTH)
            return palette_mem[idx];
        return 24'h000000;
    endfunction

    // append one predicted pixel and advance the position and line counters
    task automatic place_pixel(input logic [23:0] rgb, input logic is_last);
        pix_t p;
        p.pos   = pix_pos;
        p.red   = rgb[23:16];
        p.green = rgb[15:8];
        p.blue  = rgb[7:0];
        p.line  = line_now;
        p.eol   = (pix_pos >= PIXELS_PER_LINE - 1);
        p.last  = is_last;
        pixels_due.push_back(p);
        if (p.eol)
        begin
            pix_pos  = '0;
            line_now = line_now + 16'd1;
            if (line_now >= lines_cfg)
                line_now = '0;
        end
        else
        begin
            pix_pos = pix_pos + 8'd1;
        end
    endtask

    // work out the pixels that one accepted item request causes
    task automatic unpack_item(input req_t r);
        int b;
        if (r.op == OP_PALETTE_WRITE)
        begin
            if (r.pal_idx < PALETTE_DEPTH)
                palette_mem[r.pal_idx] = r.color;
        end
        else
        begin
            case (fmt_cur)
                FMT_1BIT:
                begin
                    // lsb first, each bit picks entry 0 or 1
                    tc_phase = '0;
                    for (b = 0; b < 8; b++)
                        place_pixel(pal_lookup({7'd0, r.data[b]}), b == 7);
                end
                FMT_4BIT:
                begin
                    // high nibble first
                    tc_phase = '0;
                    place_pixel(pal_lookup({4'd0, r.data[7:4]}), 1'b0);
                    place_pixel(pal_lookup(r.data & NIBBLE_MASK), 1'b1);
                end
                FMT_8BIT:
                begin
                    tc_phase = '0;
                    place_pixel(pal_lookup(r.data), 1'b1);
                end
                FMT_TRUE:
                begin
                    // red, green held; blue completes the pixel
                    case (tc_phase)
                        2'd0:
                        begin
                            tc_held  = {r.data, 8'h00};
                            tc_phase = 2'd1;
                        end
                        2'd1:
                        begin
                            tc_held[7:0] = r.data;
                            tc_phase     = 2'd2;
                        end
                        default:
                        begin
                            place_pixel({tc_held, r.data}, 1'b1);
                            tc_phase = 2'd0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // failure reporting
    // ------------------------------------------------------------------
    function automatic string pix_text(input pix_t p);
        return $sformatf("pos=%0d rgb=%h_%h_%h line=%0d eol=%b last=%b",
                         p.pos, p.red, p.green, p.blue, p.line, p.eol, p.last);
    endfunction

    // only the first ten failures are printed
    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // monitor: config shadow, prediction on item requests, pixel check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        req_t taken;
        pix_t got;
        pix_t want;
        if (!rst_n)
        begin
            item_fire = 1'b0;
        end
        else
        begin
            // register write: format write also drops a partial truecolor pixel
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_IMAGE_FORMAT)
                begin
                    fmt_cur  = fmt_t'(cfg_ch.data[1:0]);
                    tc_phase = '0;
                end
                else if (cfg_ch.index == CFG_LINE_COUNT)
                begin
                    // a line count of zero acts as one
                    lines_cfg = (cfg_ch.data == 16'd0) ? 16'd1 : cfg_ch.data;
                end
            end

            item_fire = item_ch.valid && item_ch.ready;
            if (item_fire)
            begin
                taken.op      = item_ch.operation;
                taken.pal_idx = item_ch.palette_index;
                taken.color   = item_ch.palette_color;
                taken.data    = item_ch.data_byte;
                unpack_item(taken);
                items_in_flight--;
            end

            if (pix_ch.valid && pix_ch.ready)
            begin
                got.pos   = pix_ch.pixel_index;
                got.red   = pix_ch.red;
                got.green = pix_ch.green;
                got.blue  = pix_ch.blue;
                got.line  = pix_ch.line_number;
                got.eol   = pix_ch.end_of_line;
                got.last  = pix_ch.last;
                if (pixels_due.size() == 0)
                begin
                    note_failure({"pixel with nothing expected: ", pix_text(got)});
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got !== want)
                        note_failure({"pixel mismatch, expected ", pix_text(want),
                                      " got ", pix_text(got)});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // item driver: presents queued requests at the falling edge, with gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : feed
        req_t nxt;
        if (rst_n && (!item_ch.valid || item_fire))
        begin
            // a gap burst may start only between requests
            if (gap_left == 0 && idle_on && $urandom_range(0, 99) < gap_pct)
                gap_left = $urandom_range(1, 8);
            if (gap_left > 0)
            begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (items_to_send.size() != 0)
            begin
                nxt = items_to_send.pop_front();
                item_ch.valid         <= 1'b1;
                item_ch.operation     <= nxt.op;
                item_ch.palette_index <= nxt.pal_idx;
                item_ch.palette_color <= nxt.color;
                item_ch.data_byte     <= nxt.data;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // pixel receiver: ready with random stall bursts
    always @(negedge clk)
    begin : receive
        if (rst_n)
        begin
            if (stall_left == 0 && idle_on && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                stall_left--;
                pix_ch.ready <= 1'b0;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_write(input logic [7:0] idx, input logic [23:0] color);
        req_t r;
        r.op      = OP_PALETTE_WRITE;
        r.pal_idx = idx;
        r.color   = color;
        r.data    = 8'($urandom_range(0, 255));
        pal_written[idx] = 1'b1;
        items_to_send.push_back(r);
        items_in_flight++;
    endtask

    task automatic push_byte(input logic [7:0] d);
        req_t r;
        r.op      = OP_DATA_BYTE;
        r.pal_idx = 8'($urandom_range(0, 255));
        r.color   = 24'($urandom_range(0, 24'hFFFFFF));
        r.data    = d;
        items_to_send.push_back(r);
        items_in_flight++;
    endtask

    // random data byte that reads only palette entries already written
    function automatic logic [7:0] pick_byte(input fmt_t f);
        logic [7:0] v;
        logic [3:0] hi;
        logic [3:0] lo;
        v = 8'($urandom_range(0, 255));
        case (f)
            FMT_1BIT:
            begin
                if (!pal_written[0])
                    v = 8'hFF;
                if (!pal_written[1])
                    v = 8'h00;
            end
            FMT_4BIT:
            begin
                hi = 4'($urandom_range(0, 15));
                while (!pal_written[hi])
                    hi = 4'($urandom_range(0, 15));
                lo = 4'($urandom_range(0, 15));
                while (!pal_written[lo])
                    lo = 4'($urandom_range(0, 15));
                v = {hi, lo};
            end
            FMT_8BIT:
            begin
                while (!pal_written[v])
                    v = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
        return v;
    endfunction

    // write both registers back to back; valid stays high across the pair
    task automatic program_regs(input fmt_t f, input logic [15:0] lines);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_IMAGE_FORMAT;
        cfg_ch.data  <= {14'd0, f};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.index <= CFG_LINE_COUNT;
        cfg_ch.data  <= lines;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every request is taken and every pixel seen, then let the
    // pipeline run dry in case the last requests caused no pixel
    task automatic settle();
        int waited;
        waited = 0;
        while ((items_in_flight != 0 || pixels_due.size() != 0) && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (items_in_flight != 0)
            note_failure($sformatf("%0d requests never accepted", items_in_flight));
        if (pixels_due.size() != 0)
        begin
            note_failure($sformatf("%0d expected pixels never arrived", pixels_due.size()));
            pixels_due.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        fmt_t        phase_fmt [7];
        logic [15:0] phase_lines [7];
        int          ph;

        clk   = 1'b0;
        rst_n = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.operation     = OP_PALETTE_WRITE;
        item_ch.palette_index = '0;
        item_ch.palette_color = '0;
        item_ch.data_byte     = '0;
        pix_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_IMAGE_FORMAT;
        cfg_ch.data           = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        gap_pct   = 30;
        stall_pct = 20;

        // reset settings: one-bit format, a single line that keeps wrapping
        push_write(8'd0, 24'h000000);
        push_write(8'd1, 24'hFFFFFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        settle();

        // four-bit, line count zero acts as one
        program_regs(FMT_4BIT, 16'd0);
        push_write(8'd15, 24'hFF0000);
        push_byte(8'hF0);
        push_byte(8'h0F);
        push_byte(8'h1F);
        settle();

        // eight-bit, widest line count, top and middle entries
        program_regs(FMT_8BIT, 16'hFFFF);
        push_write(8'd255, 24'h00FF00);
        push_write(8'd128, 24'h0000FF);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h00);
        settle();

        // truecolor: a palette write inside a triple leaves the triple intact,
        // and the phase ends with two bytes of a pixel never completed
        program_regs(FMT_TRUE, 16'd3);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_write(8'd2, 24'h123456);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hAB);
        push_byte(8'hCD);
        settle();

        // rewriting the format drops the partial pixel
        program_regs(FMT_TRUE, 16'd3);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(8'h33);
        settle();

        // random phases, each with its own settings
        phase_fmt[0]   = FMT_8BIT;
        phase_fmt[1]   = FMT_1BIT;
        phase_fmt[2]   = FMT_TRUE;
        phase_fmt[3]   = FMT_4BIT;
        phase_fmt[4]   = fmt_t'($urandom_range(0, 3));
        phase_fmt[5]   = fmt_t'($urandom_range(0, 3));
        phase_fmt[6]   = FMT_1BIT;
        phase_lines[0] = 16'd2;
        phase_lines[1] = 16'd1;
        phase_lines[2] = 16'hFFFF;
        phase_lines[3] = 16'($urandom_range(1, 5));
        phase_lines[4] = 16'($urandom_range(0, 65535));
        phase_lines[5] = 16'd0;
        phase_lines[6] = 16'd3;

        for (ph = 0; ph < 7; ph++)
        begin
            // one stretch without idling mid-run, none at all in the last phase
            idle_on   = (ph != 6);
            gap_pct   = (ph == 3) ? 0 : $urandom_range(10, 60);
            stall_pct = (ph == 3) ? 0 : $urandom_range(5, 30);
            program_regs(phase_fmt[ph], phase_lines[ph]);
            repeat (12)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // half the writes land in the low sixteen entries
                    if ($urandom_range(0, 1) == 0)
                        push_write(8'($urandom_range(0, 15)),
                                   24'($urandom_range(0, 24'hFFFFFF)));
                    else
                        push_write(8'($urandom_range(0, 255)),
                                   24'($urandom_range(0, 24'hFFFFFF)));
                end
                else
                begin
                    push_byte(pick_byte(phase_fmt[ph]));
                end
            end
            settle();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
